>>> src/trid_pkg.sv
// trid_pkg: shared constants for the threshold run interval detector
// field widths, compare operator codes, register indexes and reset values
// no dependencies
package trid_pkg;

    localparam int unsigned ValueW  = 32;
    localparam int unsigned PosW    = 32;
    localparam int unsigned EndW    = PosW + 1;
    localparam int unsigned OpW     = 3;
    localparam int unsigned StepW   = 24;
    localparam int unsigned ChromW  = 10;
    localparam int unsigned AddrW   = 4;
    localparam int unsigned DataW   = 32;

    // s_tdata: sample_value, position
    localparam int unsigned InDataW  = ValueW + PosW;
    // m_tdata: interval_chrom, interval_start, interval_end, zero padding to bytes
    localparam int unsigned OutFieldW = ChromW + PosW + EndW;
    localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;

    // compare operators
    localparam logic [OpW-1:0] OP_LT = 3'd0;
    localparam logic [OpW-1:0] OP_LE = 3'd1;
    localparam logic [OpW-1:0] OP_EQ = 3'd2;
    localparam logic [OpW-1:0] OP_GE = 3'd3;
    localparam logic [OpW-1:0] OP_GT = 3'd4;

    // register indexes, byte address 4*i
    localparam logic [1:0] REG_COMPARE_OP = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE  = 2'd2;
    localparam logic [1:0] REG_CHROM_ID   = 2'd3;

    localparam logic [OpW-1:0]    RST_COMPARE_OP = OP_GE;
    localparam logic [StepW-1:0]  RST_STEP_SIZE  = 24'd1;

    // input item mode
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_BREAK  = 1'b1;

endpackage

>>> src/threshold_run_interval_detector.sv
// threshold_run_interval_detector: an item that closes a run puts its interval on m_tdata
// through the input register, then the result register; one sample per cycle while m_tready
// keeps the result side moving, set by the combinational compare and run update between the two registers
// aresetn (synchronous, active low) closes any open run, empties both registers and
// returns the config registers to op greater-equal, threshold 0, step 1, chrom 0
// depends on trid_pkg
module threshold_run_interval_detector (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [trid_pkg::InDataW-1:0]       s_tdata,  // sample_value [31:0], position [63:32]
    input  logic                               s_tuser,  // mode: 0 sample, 1 break
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [trid_pkg::OutDataW-1:0]      m_tdata,  // interval_chrom [9:0], interval_start [41:10],
                                                         // interval_end [74:42], zeros above
    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [trid_pkg::AddrW-1:0]         paddr,
    input  logic [trid_pkg::DataW-1:0]         pwdata,
    output logic [trid_pkg::DataW-1:0]         prdata,
    output logic                               pready
);

    // config registers
    logic [trid_pkg::OpW-1:0]           compare_op_reg;
    logic signed [trid_pkg::ValueW-1:0] threshold_reg;
    logic [trid_pkg::StepW-1:0]         step_size_reg;
    logic [trid_pkg::ChromW-1:0]        chrom_id_reg;

    // input register
    logic                               in_valid_reg;
    logic                               in_mode_reg;
    logic signed [trid_pkg::ValueW-1:0] in_value_reg;
    logic [trid_pkg::PosW-1:0]          in_pos_reg;

    // run state
    logic                               run_open_reg, run_open_next;
    logic [trid_pkg::PosW-1:0]          run_first_reg, run_first_next;
    logic [trid_pkg::PosW-1:0]          run_last_reg, run_last_next;

    // result register
    logic                               out_valid_reg, out_valid_next;
    logic [trid_pkg::OutDataW-1:0]      out_data_reg;

    logic                               cfg_write;
    logic                               advance;
    logic                               passes;
    logic                               emit;
    logic                               gap;
    logic [trid_pkg::EndW-1:0]          run_end;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            compare_op_reg <= trid_pkg::RST_COMPARE_OP;
            threshold_reg  <= '0;
            step_size_reg  <= trid_pkg::RST_STEP_SIZE;
            chrom_id_reg   <= '0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                trid_pkg::REG_COMPARE_OP: compare_op_reg <= pwdata[trid_pkg::OpW-1:0];
                trid_pkg::REG_THRESHOLD:  threshold_reg  <= pwdata[trid_pkg::ValueW-1:0];
                trid_pkg::REG_STEP_SIZE:  step_size_reg  <= pwdata[trid_pkg::StepW-1:0];
                trid_pkg::REG_CHROM_ID:   chrom_id_reg   <= pwdata[trid_pkg::ChromW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            trid_pkg::REG_COMPARE_OP:
                prdata = {{(trid_pkg::DataW-trid_pkg::OpW){1'b0}}, compare_op_reg};
            trid_pkg::REG_THRESHOLD:
                prdata = threshold_reg;
            trid_pkg::REG_STEP_SIZE:
                prdata = {{(trid_pkg::DataW-trid_pkg::StepW){1'b0}}, step_size_reg};
            trid_pkg::REG_CHROM_ID:
                prdata = {{(trid_pkg::DataW-trid_pkg::ChromW){1'b0}}, chrom_id_reg};
            default:
                prdata = '0;
        endcase
    end

    // second stage moves when the result register is free or being drained
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= s_tuser;
            in_value_reg <= s_tdata[trid_pkg::ValueW-1:0];
            in_pos_reg   <= s_tdata[trid_pkg::InDataW-1:trid_pkg::ValueW];
        end
    end

    always_comb begin
        case (compare_op_reg)
            trid_pkg::OP_LT: passes = in_value_reg <  threshold_reg;
            trid_pkg::OP_LE: passes = in_value_reg <= threshold_reg;
            trid_pkg::OP_EQ: passes = in_value_reg == threshold_reg;
            trid_pkg::OP_GE: passes = in_value_reg >= threshold_reg;
            trid_pkg::OP_GT: passes = in_value_reg >  threshold_reg;
            default:         passes = 1'b0;
        endcase
    end

    assign run_end = {1'b0, run_last_reg}
                   + {{(trid_pkg::EndW-trid_pkg::StepW){1'b0}}, step_size_reg};
    assign gap     = {1'b0, in_pos_reg} > run_end;

    always_comb begin
        emit           = 1'b0;
        run_open_next  = run_open_reg;
        run_first_next = run_first_reg;
        run_last_next  = run_last_reg;
        if (in_mode_reg == trid_pkg::MODE_SAMPLE && passes) begin
            if (!run_open_reg || gap) begin
                // old run (if any) goes out, a new one opens here
                emit           = run_open_reg;
                run_open_next  = 1'b1;
                run_first_next = in_pos_reg;
            end
            run_last_next = in_pos_reg;
        end else begin
            emit           = run_open_reg;
            run_open_next  = 1'b0;
            run_first_next = '0;
            run_last_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg  <= 1'b0;
            run_first_reg <= '0;
            run_last_reg  <= '0;
        end else if (advance) begin
            run_open_reg  <= run_open_next;
            run_first_reg <= run_first_next;
            run_last_reg  <= run_last_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_data_reg <= {{(trid_pkg::OutDataW-trid_pkg::OutFieldW){1'b0}},
                             run_end, run_first_reg, chrom_id_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> src/trid_checker.sv
// trid_checker: port-level checks on the threshold run interval detector
// attached to the top level by the bind at the end of this file; depends on trid_pkg
module trid_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [trid_pkg::OutDataW-1:0]      m_tdata
);

    logic s_xfer;
    assign s_xfer = s_tvalid & s_tready;

    // a stalled result transaction holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input only backs up when a result is waiting
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // a result needs a transaction in flight: nothing appears from an empty pipe
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn, 2) && !$past(m_tvalid) && !$past(m_tvalid, 2)
            && !$past(s_xfer) && !$past(s_xfer, 2) |-> !m_tvalid)
        else $error("result from an empty pipeline");

    // reset leaves the result side empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind threshold_run_interval_detector trid_checker u_trid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench for threshold_run_interval_detector: directed and random sample streams checked
// against a predictor of the run merging, with random stalls on both stream sides
// depends on trid_pkg and the detector rtl
module testbench;
    import trid_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600_000;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned PHASE_ITEMS   = 125;

    // operator codes outside the defined set, nothing passes
    localparam logic [OpW-1:0] OP_NONE_LO = OP_GT + 3'd1;
    localparam logic [OpW-1:0] OP_NONE_HI = '1;

    localparam logic [ValueW-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [ValueW-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [StepW-1:0]  STEP_MAX  = '1;
    localparam logic [ChromW-1:0] CHROM_MAX = '1;

    typedef struct packed {
        logic [ChromW-1:0] iv_chrom;
        logic [PosW-1:0]   iv_start;
        logic [EndW-1:0]   iv_end;
    } interval_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [InDataW-1:0]    s_tdata;   // sample_value [31:0], position [63:32]
    logic                  s_tuser;   // mode
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OutDataW-1:0]   m_tdata;   // interval_chrom, interval_start, interval_end, zero pad
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [AddrW-1:0]      paddr;
    logic [DataW-1:0]      pwdata;
    logic [DataW-1:0]      prdata;
    logic                  pready;

    // configuration and run state as the detector should hold them
    logic [OpW-1:0]        cfg_op;
    logic [ValueW-1:0]     cfg_threshold;
    logic [StepW-1:0]      cfg_step;
    logic [ChromW-1:0]     cfg_chrom;
    logic                  run_active;
    logic [PosW-1:0]       run_begin;
    logic [PosW-1:0]       run_tail;

    interval_t             pending_intervals[$];
    interval_t             got_iv;
    interval_t             want_iv;
    int unsigned           error_count;
    int unsigned           cycle_count;
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;
    int unsigned           stall_left;

    threshold_run_interval_detector uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** threshold_run_interval_detector: FAILED **");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic value_passes(input logic signed [ValueW-1:0] v,
                                          input logic signed [ValueW-1:0] t,
                                          input logic [OpW-1:0] op);
        case (op)
            OP_LT: return v < t;
            OP_LE: return v <= t;
            OP_EQ: return v == t;
            OP_GE: return v >= t;
            OP_GT: return v > t;
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic close_run();
        interval_t iv;
        if (run_active) begin
            iv.iv_chrom = cfg_chrom;
            iv.iv_start = run_begin;
            iv.iv_end   = {1'b0, run_tail} + EndW'(cfg_step);
            pending_intervals.insert(pending_intervals.size(), iv);
        end
        run_active = 1'b0;
        run_begin  = '0;
        run_tail   = '0;
    endtask

    task automatic predict_interval(input logic mode, input logic [ValueW-1:0] value,
                                    input logic [PosW-1:0] pos);
        logic [EndW-1:0] reach;
        if (mode == MODE_BREAK) begin
            close_run();
        end else if (value_passes(value, cfg_threshold, cfg_op)) begin
            reach = {1'b0, run_tail} + EndW'(cfg_step);
            if (!run_active || {1'b0, pos} > reach) begin
                close_run();
                run_active = 1'b1;
                run_begin  = pos;
            end
            run_tail = pos;
        end else begin
            close_run();
        end
    endtask

    // valid stays high after acceptance so that back-to-back items can follow each other directly
    task automatic send_item(input logic mode, input logic [ValueW-1:0] value,
                             input logic [PosW-1:0] pos);
        int unsigned gap;
        gap = pick_gap(send_idle_pct);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {pos, value};
        do @(posedge aclk); while (!s_tready);
        predict_interval(mode, value, pos);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_intervals.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [DataW-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_COMPARE_OP: cfg_op        = value[OpW-1:0];
            REG_THRESHOLD:  cfg_threshold = value[ValueW-1:0];
            REG_STEP_SIZE:  cfg_step      = value[StepW-1:0];
            REG_CHROM_ID:   cfg_chrom     = value[ChromW-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [OpW-1:0] op, input logic [ValueW-1:0] thr,
                             input logic [StepW-1:0] step, input logic [ChromW-1:0] chrom);
        wait_idle();
        write_register(REG_COMPARE_OP, DataW'(op));
        write_register(REG_THRESHOLD, thr);
        write_register(REG_STEP_SIZE, DataW'(step));
        write_register(REG_CHROM_ID, DataW'(chrom));
    endtask

    // reset settings: merging, a gap, a backward position, idle breaks and fails
    task automatic test_reset_settings();
        send_item(MODE_BREAK, $urandom, $urandom);
        send_item(MODE_SAMPLE, 32'hFFFF_FFFF, 32'd5);
        send_item(MODE_SAMPLE, 32'd0, 32'd10);
        send_item(MODE_SAMPLE, VALUE_MAX, 32'd11);
        send_item(MODE_SAMPLE, 32'h0001_0000, 32'd13);
        send_item(MODE_SAMPLE, 32'd5, 32'd12);
        // registers change under an open run, interval takes the new step and chrom
        configure(OP_GE, '0, STEP_MAX, CHROM_MAX);
        send_item(MODE_SAMPLE, VALUE_MIN, 32'd0);
    endtask

    // top position with the widest step overflows into the end's extra bit
    task automatic test_position_extremes();
        send_item(MODE_SAMPLE, 32'd1, 32'hFFFF_FFFF);
        send_item(MODE_BREAK, $urandom, $urandom);
    endtask

    task automatic test_zero_step();
        configure(OP_GE, '0, '0, 10'h155);
        send_item(MODE_SAMPLE, 32'd7, 32'd100);
        send_item(MODE_SAMPLE, 32'd7, 32'd100);
        send_item(MODE_SAMPLE, 32'd7, 32'd101);
        send_item(MODE_BREAK, $urandom, $urandom);
    endtask

    // each operator around its threshold, then the codes with no operator
    task automatic test_operators();
        logic [OpW-1:0]    ops [5] = '{OP_LT, OP_LE, OP_EQ, OP_GE, OP_GT};
        logic [ValueW-1:0] thrs[5] = '{VALUE_MIN, 32'hFFFF_0000, 32'h0001_8000,
                                       32'h0000_0001, VALUE_MAX};
        logic [PosW-1:0]   pos;
        pos = 32'd1000;
        for (int k = 0; k < 5; k++) begin
            configure(ops[k], thrs[k], 24'd1, ChromW'(k));
            for (int d = -1; d <= 1; d++) begin
                send_item(MODE_SAMPLE, thrs[k] + ValueW'(d), pos);
                pos++;
            end
        end
        configure(OP_NONE_LO, '0, 24'd1, 10'h2AA);
        send_item(MODE_SAMPLE, 32'd5, pos);
        configure(OP_NONE_HI, '0, 24'd1, 10'h0F0);
        send_item(MODE_SAMPLE, 32'd0, pos + 1);
        configure(OP_GE, '0, 24'd1, '0);
        send_item(MODE_SAMPLE, 32'd0, pos + 2);
        send_item(MODE_BREAK, $urandom, $urandom);
    endtask

    function automatic logic [ValueW-1:0] passing_value();
        logic [ValueW-1:0] d;
        d = $urandom_range(0, 3);
        case (cfg_op)
            OP_LT: return cfg_threshold - 32'd1 - d;
            OP_LE: return cfg_threshold - d;
            OP_EQ: return cfg_threshold;
            OP_GE: return cfg_threshold + d;
            OP_GT: return cfg_threshold + 32'd1 + d;
            default: return cfg_threshold + d;
        endcase
    endfunction

    // mostly runs of passing samples with random content, mixed with fails, gaps and breaks
    task automatic test_random_runs();
        logic [OpW-1:0]    op;
        logic [ValueW-1:0] thr;
        logic [StepW-1:0]  step;
        logic [ChromW-1:0] chrom;
        logic [PosW-1:0]   cur_pos;
        logic [ValueW-1:0] value;
        int unsigned       r;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 5) begin
                op = OP_LT + OpW'(p);
            end else if ($urandom_range(7) == 0) begin
                op = OpW'($urandom_range(OP_NONE_LO, OP_NONE_HI));
            end else begin
                op = OpW'($urandom_range(OP_LT, OP_GT));
            end
            thr   = (p == 1) ? VALUE_MIN : (p == 2) ? VALUE_MAX : $urandom;
            step  = (p == 3) ? '0 : (p == 4) ? STEP_MAX : (p == 7) ? StepW'($urandom) :
                    StepW'($urandom_range(1, 8));
            chrom = (p == 5) ? '0 : (p == 6) ? CHROM_MAX : ChromW'($urandom);
            configure(op, thr, step, chrom);
            send_idle_pct  = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 15 : 40;
            recv_stall_pct = ((p + 1) % 3 == 0) ? 0 : ((p + 1) % 3 == 1) ? 20 : 45;
            cur_pos = $urandom;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(99) < 6) begin
                    send_item(MODE_BREAK, $urandom, $urandom);
                end else begin
                    r = $urandom_range(99);
                    if (r < 70) value = passing_value();
                    else if (r < 90) value = cfg_threshold + ValueW'($urandom_range(0, 6)) - 32'd3;
                    else value = $urandom;
                    r = $urandom_range(99);
                    if (r < 80) cur_pos = cur_pos + PosW'($urandom_range(0, cfg_step));
                    else if (r < 90) cur_pos = cur_pos + PosW'(cfg_step) + 32'd1 +
                                               PosW'($urandom_range(0, 50));
                    else if (r < 96) cur_pos = cur_pos - PosW'($urandom_range(0, 20));
                    else cur_pos = $urandom;
                    send_item(MODE_SAMPLE, value, cur_pos);
                end
            end
        end
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap(recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_iv.iv_chrom = m_tdata[ChromW-1:0];
            got_iv.iv_start = m_tdata[ChromW +: PosW];
            got_iv.iv_end   = m_tdata[ChromW + PosW +: EndW];
            if (pending_intervals.size() == 0) begin
                report_mismatch("interval with none pending", 64'(got_iv.iv_start), '0);
            end else begin
                want_iv = pending_intervals.pop_front();
                if (got_iv.iv_chrom != want_iv.iv_chrom)
                    report_mismatch("interval_chrom", 64'(got_iv.iv_chrom), 64'(want_iv.iv_chrom));
                if (got_iv.iv_start != want_iv.iv_start)
                    report_mismatch("interval_start", 64'(got_iv.iv_start), 64'(want_iv.iv_start));
                if (got_iv.iv_end != want_iv.iv_end)
                    report_mismatch("interval_end", 64'(got_iv.iv_end), 64'(want_iv.iv_end));
                if (m_tdata[OutDataW-1:OutFieldW] != '0)
                    report_mismatch("m_tdata padding", 64'(m_tdata[OutDataW-1:OutFieldW]), '0);
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = MODE_SAMPLE;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        error_count    = 0;
        stall_left     = 0;
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        cfg_op         = RST_COMPARE_OP;
        cfg_threshold  = '0;
        cfg_step       = RST_STEP_SIZE;
        cfg_chrom      = '0;
        run_active     = 1'b0;
        run_begin      = '0;
        run_tail       = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_settings();
        test_position_extremes();
        test_zero_step();
        test_operators();
        test_random_runs();
        wait_idle();

        if (error_count == 0) begin
            $display("** threshold_run_interval_detector: PASSED **");
        end else begin
            $display("** threshold_run_interval_detector: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/trid_pkg.sv
src/threshold_run_interval_detector.sv
src/trid_checker.sv
dv/testbench.sv
